@@ design/grm_pkg.sv @@
package grm_pkg;

	// Default grid capacity in vertices.
	localparam int MAX_VERTICES_DEF = 32768;

	// Field and register widths.
	localparam int PHI_W      = 16;
	localparam int ID_W       = 15;
	localparam int LEN_W      = 11;
	localparam int RING_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SUM_W      = 20;

	// Input operation codes.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RING_WIDTH = 2'd3;

	// Register reset values.
	localparam logic [LEN_W-1:0]  COLUMN_LENGTH_RST  = 11'd141;
	localparam logic [PHI_W-1:0]  LOW_THRESHOLD_RST  = 16'd1638;
	localparam logic [PHI_W-1:0]  HIGH_THRESHOLD_RST = 16'd15565;
	localparam logic [RING_W-1:0] RING_WIDTH_RST     = 2'd1;
	localparam logic [LEN_W-1:0]  LEN_MIN            = 11'd3;

	// Stencil tap counter: taps 0..8 are issued, the sum closes on the last one.
	localparam logic [3:0] TAP_LAST = 4'd9;
	localparam logic [3:0] TAP_ADD_LAST = 4'd8;

	// Accumulator control from the sequencer.
	typedef struct packed {
		logic clear;
		logic add;
	} acc_ctl_t;

	// Sequencer states.
	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_START    = 14'b00000000000010,
		S_P1       = 14'b00000000000100,
		S_P2_RD    = 14'b00000000001000,
		S_P2_CHK   = 14'b00000000010000,
		S_P2_WR    = 14'b00000000100000,
		S_P3_INIT  = 14'b00000001000000,
		S_P3_FIRST = 14'b00000010000000,
		S_P3_RD    = 14'b00000100000000,
		S_P3_EV    = 14'b00001000000000,
		S_DONE     = 14'b00010000000000,
		S_F_RD     = 14'b00100000000000,
		S_F_CHK    = 14'b01000000000000,
		S_F_PUT    = 14'b10000000000000
	} state_t;

endpackage

@@ design/grm_stencil_acc.sv @@
module grm_stencil_acc
	import grm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  acc_ctl_t                ctl,
	input  logic signed [PHI_W-1:0] sample,
	input  logic signed [PHI_W-1:0] low_threshold,
	input  logic signed [PHI_W-1:0] high_threshold,
	output logic                    in_band
);

	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] lo9_q;
	logic signed [SUM_W-1:0] hi9_q;
	logic signed [SUM_W-1:0] total;

	// Running sum of the stencil taps; the band edges are scaled by nine on clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			lo9_q <= '0;
			hi9_q <= '0;
		end else if (ctl.clear) begin
			sum_q <= '0;
			lo9_q <= (SUM_W'(low_threshold) <<< 3) + SUM_W'(low_threshold);
			hi9_q <= (SUM_W'(high_threshold) <<< 3) + SUM_W'(high_threshold);
		end else if (ctl.add) begin
			sum_q <= sum_q + SUM_W'(sample);
		end
	end

	// The last tap joins the sum on the fly for the band compare.
	assign total   = sum_q + SUM_W'(sample);
	assign in_band = (total > lo9_q) && (total < hi9_q);

endmodule

@@ design/grid_refinement_marker.sv @@
// Marks elements of a structured grid for refinement.
// Input channel (in_valid/in_stall): op 0 loads one phase sample in column-major
// order; a load with last_sample set starts processing, during which in_stall
// stays high. Processing runs three passes over the stores through one shared
// address/accumulate unit: the 3x3 sum per entry, the support ring with (2r+1)^2
// writes per refined entry, and the gap fill.
// op 1 fetches the next kept entry, scanning the stored entries one at a time
// through the single mark store read port. One request is in work at a time.
// Output channel (out_valid/out_stall): one result per fetch, held in an output
// register; while the receiver stalls, loads are still taken and a finished fetch
// waits for the register to free up.
// Configuration: cfg_we/cfg_index/cfg_data, to be written by the user only while
// the block is idle; the block itself does not enforce this.
// Reset clears control state and returns the block to loading; the stores are not
// cleared, and a fetch before processing returns an exhausted entry.
module grid_refinement_marker
	import grm_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     op,
	input  logic signed [PHI_W-1:0]  phi_sample,
	input  logic                     last_sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [ID_W-1:0]          element_id,
	output logic                     refine_kind,
	output logic                     entry_valid,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int VW = $clog2(MAX_VERTICES + 1);
	localparam int CW = ((VW > 13) ? VW : 13) + 2;

	// Configuration registers.
	logic [LEN_W-1:0]        column_length_q;
	logic signed [PHI_W-1:0] low_threshold_q;
	logic signed [PHI_W-1:0] high_threshold_q;
	logic [RING_W-1:0]       ring_width_q;

	// Control state.
	state_t            state_q;
	logic [VW-1:0]     count_q;
	logic              ready_q;
	logic [LEN_W-1:0]  stride_q;
	logic [VW-1:0]     ecnt_q;
	logic [RING_W-1:0] ring_q;
	logic [CW-1:0]     rl1_q;
	logic [CW-1:0]     k_q;
	logic [CW-1:0]     addr_q;
	logic [3:0]        t_q;
	logic [2:0]        a_q;
	logic [2:0]        b_q;
	logic              left_q;
	logic              cur_q;
	logic [VW-1:0]     fp_q;
	logic [VW-1:0]     quo_q;
	logic [LEN_W-1:0]  rem_q;
	logic [ID_W-1:0]   stage_id_q;
	logic              stage_kind_q;
	logic              stage_vld_q;
	logic              out_valid_q;
	logic [ID_W-1:0]   element_id_q;
	logic              refine_kind_q;
	logic              entry_valid_q;

	// Stores.
	logic [PHI_W-1:0] phase_mem [MAX_VERTICES];
	logic             refine_mem [MAX_VERTICES];
	logic             support_mem [MAX_VERTICES];
	logic [PHI_W-1:0] prd_q;
	logic             rref_q;
	logic             rsup_q;

	// Store port controls.
	logic          ph_we;
	logic [AW-1:0] ph_waddr;
	logic [AW-1:0] ph_raddr;
	logic          ref_we;
	logic          ref_wdata;
	logic          sup_we;
	logic [AW-1:0] sup_waddr;
	logic          sup_wdata;
	logic [AW-1:0] mk_raddr;

	logic [VW-1:0]    ld_idx;
	logic             ld_room;
	logic [LEN_W-1:0] l_clamp;
	logic [CW-1:0]    two_l2;
	logic [CW-1:0]    v_ext;
	logic [CW-1:0]    l1;
	logic [2:0]       span;
	logic             marked;
	logic             right;
	logic             fill;
	logic             out_free;
	logic             out_load;
	logic [CW-1:0]    id_full;
	logic             in_band;
	acc_ctl_t         acc_ctl;

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign element_id  = element_id_q;
	assign refine_kind = refine_kind_q;
	assign entry_valid = entry_valid_q;

	assign ld_idx   = ready_q ? '0 : count_q;
	assign ld_room  = (ld_idx < VW'(MAX_VERTICES));
	assign l_clamp  = (column_length_q < LEN_MIN) ? LEN_MIN : column_length_q;
	assign two_l2   = CW'({l_clamp, 1'b0}) + CW'(2);
	assign l1       = CW'(l_clamp) + CW'(1);
	assign v_ext    = CW'(count_q);
	assign span     = {ring_q, 1'b0};
	assign marked   = rref_q | rsup_q;
	assign right    = ((k_q + CW'(1)) < CW'(ecnt_q)) && marked;
	assign fill     = !cur_q && left_q && right;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_F_PUT) && out_free;
	assign id_full  = CW'(fp_q) + CW'(stride_q) + CW'(1) - CW'(quo_q);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_length_q  <= COLUMN_LENGTH_RST;
			low_threshold_q  <= LOW_THRESHOLD_RST;
			high_threshold_q <= HIGH_THRESHOLD_RST;
			ring_width_q     <= RING_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COLUMN_LENGTH: column_length_q <= cfg_data[LEN_W-1:0];
				REG_LOW_THRESHOLD: low_threshold_q <= cfg_data;
				REG_HIGH_THRESHOLD: high_threshold_q <= cfg_data;
				REG_RING_WIDTH: ring_width_q <= cfg_data[RING_W-1:0];
				default: ;
			endcase
		end
	end

	// Store port selection by sequencer state.
	always_comb begin
		ph_we     = 1'b0;
		ph_waddr  = ld_idx[AW-1:0];
		ph_raddr  = addr_q[AW-1:0];
		ref_we    = 1'b0;
		ref_wdata = in_band;
		sup_we    = 1'b0;
		sup_waddr = k_q[AW-1:0];
		sup_wdata = 1'b0;
		mk_raddr  = k_q[AW-1:0];
		acc_ctl   = '0;
		case (state_q)
			S_IDLE: begin
				ph_we = in_valid && (op == OP_LOAD) && ld_room;
			end
			S_P1: begin
				acc_ctl.clear = (t_q == '0);
				acc_ctl.add   = (t_q != '0) && (t_q <= TAP_ADD_LAST);
				if (t_q == TAP_LAST) begin
					ref_we = 1'b1;
					sup_we = 1'b1;
				end
			end
			S_P2_WR: begin
				sup_we    = 1'b1;
				sup_waddr = addr_q[AW-1:0];
				sup_wdata = 1'b1;
			end
			S_P3_INIT: mk_raddr = '0;
			S_P3_RD: mk_raddr = AW'(k_q + CW'(1));
			S_P3_EV: begin
				sup_we    = fill;
				sup_wdata = 1'b1;
			end
			S_F_RD: mk_raddr = fp_q[AW-1:0];
			default: ;
		endcase
	end

	// Phase store.
	always_ff @(posedge clk) begin
		if (ph_we) begin
			phase_mem[ph_waddr] <= phi_sample;
		end
		prd_q <= phase_mem[ph_raddr];
	end

	// Mark stores: refine flag and support flag per entry.
	always_ff @(posedge clk) begin
		if (ref_we) begin
			refine_mem[k_q[AW-1:0]] <= ref_wdata;
		end
		if (sup_we) begin
			support_mem[sup_waddr] <= sup_wdata;
		end
		rref_q <= refine_mem[mk_raddr];
		rsup_q <= support_mem[mk_raddr];
	end

	grm_stencil_acc u_acc (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (acc_ctl),
		.sample         (prd_q),
		.low_threshold  (low_threshold_q),
		.high_threshold (high_threshold_q),
		.in_band        (in_band)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			ready_q      <= 1'b0;
			stride_q     <= LEN_MIN;
			ecnt_q       <= '0;
			ring_q       <= '0;
			rl1_q        <= '0;
			k_q          <= '0;
			addr_q       <= '0;
			t_q          <= '0;
			a_q          <= '0;
			b_q          <= '0;
			left_q       <= 1'b0;
			cur_q        <= 1'b0;
			fp_q         <= '0;
			quo_q        <= VW'(1);
			rem_q        <= LEN_W'(1);
			stage_id_q   <= '0;
			stage_kind_q <= 1'b0;
			stage_vld_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			element_id_q <= '0;
			refine_kind_q <= 1'b0;
			entry_valid_q <= 1'b0;
		end else begin
			// The output register empties when its request is taken and nothing refills it.
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (op == OP_LOAD) begin
							ready_q <= 1'b0;
							count_q <= ld_room ? ld_idx + VW'(1) : ld_idx;
							if (last_sample) begin
								state_q <= S_START;
							end
						end else begin
							state_q <= S_F_RD;
						end
					end
				end
				// Latch the grid geometry and entry count.
				S_START: begin
					stride_q <= l_clamp;
					ecnt_q   <= (v_ext > two_l2) ? VW'(v_ext - two_l2) : '0;
					if ((ring_width_q == 2'd1) || (ring_width_q == 2'd2)) begin
						ring_q <= ring_width_q;
						rl1_q  <= (ring_width_q == 2'd2) ? (l1 << 1) : l1;
					end else begin
						ring_q <= '0;
						rl1_q  <= '0;
					end
					fp_q    <= '0;
					quo_q   <= VW'(1);
					rem_q   <= LEN_W'(1);
					k_q     <= '0;
					addr_q  <= '0;
					t_q     <= '0;
					a_q     <= '0;
					b_q     <= '0;
					state_q <= S_P1;
				end
				// Pass one: nine taps per entry, then the band compare.
				S_P1: begin
					if ((t_q == '0) && (k_q >= CW'(ecnt_q))) begin
						k_q <= rl1_q;
						state_q <= (ring_q == '0) ? S_P3_INIT : S_P2_RD;
					end else if (t_q == TAP_LAST) begin
						k_q    <= k_q + CW'(1);
						addr_q <= k_q + CW'(1);
						t_q    <= '0;
						a_q    <= '0;
						b_q    <= '0;
					end else begin
						t_q <= t_q + 4'd1;
						if (b_q == 3'd2) begin
							b_q    <= '0;
							a_q    <= a_q + 3'd1;
							addr_q <= addr_q + CW'(stride_q) - CW'(2);
						end else begin
							b_q    <= b_q + 3'd1;
							addr_q <= addr_q + CW'(1);
						end
					end
				end
				// Pass two: support ring around each refined entry.
				S_P2_RD: begin
					if ((k_q + rl1_q) >= CW'(ecnt_q)) begin
						state_q <= S_P3_INIT;
					end else begin
						state_q <= S_P2_CHK;
					end
				end
				S_P2_CHK: begin
					if (rref_q) begin
						addr_q  <= k_q - rl1_q;
						a_q     <= '0;
						b_q     <= '0;
						state_q <= S_P2_WR;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= S_P2_RD;
					end
				end
				S_P2_WR: begin
					if (b_q == span) begin
						b_q <= '0;
						if (a_q == span) begin
							k_q     <= k_q + CW'(1);
							state_q <= S_P2_RD;
						end else begin
							a_q    <= a_q + 3'd1;
							addr_q <= addr_q + CW'(stride_q) - CW'(span);
						end
					end else begin
						b_q    <= b_q + 3'd1;
						addr_q <= addr_q + CW'(1);
					end
				end
				// Pass three: fill single gaps in raster order on updated marks.
				S_P3_INIT: begin
					k_q <= '0;
					state_q <= (ecnt_q == '0) ? S_DONE : S_P3_FIRST;
				end
				S_P3_FIRST: begin
					cur_q   <= marked;
					left_q  <= 1'b0;
					state_q <= S_P3_RD;
				end
				S_P3_RD: state_q <= S_P3_EV;
				S_P3_EV: begin
					left_q <= cur_q | fill;
					cur_q  <= right;
					k_q    <= k_q + CW'(1);
					state_q <= ((k_q + CW'(1)) < CW'(ecnt_q)) ? S_P3_RD : S_DONE;
				end
				S_DONE: begin
					ready_q <= 1'b1;
					state_q <= S_IDLE;
				end
				// Fetch: scan for the next kept entry.
				S_F_RD: begin
					if (!ready_q || (fp_q >= ecnt_q)) begin
						stage_id_q   <= '0;
						stage_kind_q <= 1'b0;
						stage_vld_q  <= 1'b0;
						state_q      <= S_F_PUT;
					end else begin
						state_q <= S_F_CHK;
					end
				end
				S_F_CHK: begin
					fp_q <= fp_q + VW'(1);
					if (rem_q == (stride_q - LEN_W'(1))) begin
						rem_q <= '0;
						quo_q <= quo_q + VW'(1);
					end else begin
						rem_q <= rem_q + LEN_W'(1);
					end
					if (marked) begin
						stage_id_q   <= id_full[ID_W-1:0];
						stage_kind_q <= !rref_q;
						stage_vld_q  <= 1'b1;
						state_q      <= S_F_PUT;
					end else begin
						state_q <= S_F_RD;
					end
				end
				S_F_PUT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						element_id_q  <= stage_id_q;
						refine_kind_q <= stage_kind_q;
						entry_valid_q <= stage_vld_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The fetch pointer never runs past the entry list.
	a_fp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fp_q <= ecnt_q) else $error("fetch pointer beyond entry count");

	// Ring writes happen only with a ring radius in force.
	a_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P2_WR) |-> (ring_q != '0)) else $error("ring write without radius");

	// A stencil in progress belongs to an existing entry.
	a_tap: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_P1) && (t_q != '0)) |-> (k_q < CW'(ecnt_q)))
		else $error("stencil beyond entry list");

	// The column remainder stays below the latched stride.
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < stride_q) else $error("column remainder out of range");

endmodule
